// ===== src/csc_pkg.sv =====
// Shared types, space codes and widths for the color space converter.
`timescale 1ns / 1ps

package csc_pkg;

    localparam logic [2:0] SP_RGB   = 3'd0;
    localparam logic [2:0] SP_HSV   = 3'd1;
    localparam logic [2:0] SP_HSL   = 3'd2;
    localparam logic [2:0] SP_CMY   = 3'd3;
    localparam logic [2:0] SP_Y601  = 3'd4;
    localparam logic [2:0] SP_Y709  = 3'd5;
    localparam logic [2:0] SP_YCOCG = 3'd6;

    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_TGT = 1'b1;

    localparam int NUM_W   = 40;
    localparam int DEN_W   = 32;
    localparam int DIV_LAT = 9;

    typedef struct packed {
        logic [7:0] chan_a;
        logic [7:0] chan_b;
        logic [7:0] chan_c;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_a;
        logic [7:0] out_b;
        logic [7:0] out_c;
    } t_pix_out;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } t_nd;

    typedef t_nd [2:0] t_nd3;

endpackage

// ===== src/csc_div.sv =====
// Pipelined restoring divider: truncated quotient saturated to 0..255.
`timescale 1ns / 1ps

module csc_div #(
    parameter int NW = 40,
    parameter int DW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    output logic [7:0]           o_q
);

    localparam int CW = (NW > DW + 8) ? NW : DW + 8;

    logic [CW-1:0] r_rem  [0:7];
    logic [DW-1:0] r_den  [0:7];
    logic [7:0]    r_q    [0:8];
    logic          r_zero [0:8];
    logic          r_sat  [0:8];

    logic [CW-1:0] w_num_u;
    logic [CW-1:0] w_den_sh;

    assign w_num_u  = CW'(i_num[NW-2:0]);
    assign w_den_sh = CW'(i_den) << 8;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= i_num[NW-1] || (i_num == '0);
            r_sat[0]  <= w_num_u >= w_den_sh;
            r_rem[0]  <= w_num_u;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
        end
    end

    for (genvar g = 1; g <= 8; g++) begin : g_step
        logic [CW-1:0] w_trial;
        logic          w_fit;

        assign w_trial = CW'(r_den[g-1]) << (8 - g);
        assign w_fit   = r_rem[g-1] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g]    <= {r_q[g-1][6:0], w_fit};
                r_zero[g] <= r_zero[g-1];
                r_sat[g]  <= r_sat[g-1];
            end
        end

        if (g < 8) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= w_fit ? (r_rem[g-1] - w_trial) : r_rem[g-1];
                    r_den[g] <= r_den[g-1];
                end
            end
        end
    end

    assign o_q = r_zero[8] ? 8'd0 : (r_sat[8] ? 8'hFF : r_q[8]);

endmodule

// ===== src/color_space_converter.sv =====
// Top level: pixel color space converter, fully pipelined.
`timescale 1ns / 1ps

// Usage:
//   Input channel i_valid / o_ready carries one pixel per beat in i_pix.
//   Output channel o_valid / i_ready carries one converted pixel in o_pix.
//   Write i_cfg_we / i_cfg_idx / i_cfg_data to set the source space (index 0)
//   and the target space (index 1) while no beat is in flight.
//   Throughput: one pixel per cycle while the output is not stalled; every stage advances together.
//   The path is four conversion passes (pre-step, to RGB, from RGB,
//   post-step), each with its own product stages, a numerator/denominator stage
//   and a 9-stage pipelined divider per channel.
//   A stalled output beat holds o_pix; the whole pipeline freezes with it and
//   o_ready drops, so no beat is lost or repeated. Bubbles keep the
//   pipeline moving while the receiver is not waiting.
//   Reset clears the valid chain and sets both spaces to RGB.

module color_space_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  csc_pkg::t_pix_in    i_pix,
    output logic                o_valid,
    input  logic                i_ready,
    output csc_pkg::t_pix_out   o_pix,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [2:0]          i_cfg_data
);

    localparam int LAT = 1 + (2 + csc_pkg::DIV_LAT) + (4 + csc_pkg::DIV_LAT)
                       + (2 + csc_pkg::DIV_LAT) + (2 + csc_pkg::DIV_LAT);

    localparam logic [1:0] HR_RISE = 2'd0;
    localparam logic [1:0] HR_TOP  = 2'd1;
    localparam logic [1:0] HR_FALL = 2'd2;
    localparam logic [1:0] HR_LOW  = 2'd3;

    typedef struct packed {
        logic [1:0] rg;
        logic [9:0] f;
    } t_hue;

    function automatic logic signed [39:0] s40(input logic [26:0] x);
        return signed'(40'(x));
    endfunction

    function automatic csc_pkg::t_nd mk(input logic signed [39:0] num,
                                        input logic [31:0] den);
        csc_pkg::t_nd nd;
        nd.num = num;
        nd.den = den;
        return nd;
    endfunction

    function automatic csc_pkg::t_nd3 f_ident(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        csc_pkg::t_nd3 nd;
        nd[0] = mk(s40(27'(a)), 32'd1);
        nd[1] = mk(s40(27'(b)), 32'd1);
        nd[2] = mk(s40(27'(c)), 32'd1);
        return nd;
    endfunction

    function automatic logic [7:0] f_hsl_m(input logic [7:0] l);
        return (l <= 8'd127) ? l : (8'd255 - l);
    endfunction

    function automatic csc_pkg::t_nd3 f_hsv_nd(input logic [7:0] h, input logic [7:0] s,
                                               input logic [7:0] l, input logic [15:0] sm);
        csc_pkg::t_nd3 nd;
        logic [16:0]   den;
        den   = 17'(l) * 17'd255 + 17'(sm);
        nd[0] = mk(s40(27'(h)), 32'd1);
        nd[1] = mk(s40(27'(sm)) * 40'sd510, 32'(den));
        nd[2] = mk(s40(27'(den)), 32'd255);
        return nd;
    endfunction

    function automatic csc_pkg::t_nd3 f_hsl_nd(input logic [7:0] h, input logic [7:0] s,
                                               input logic [16:0] n, input logic [15:0] sv);
        csc_pkg::t_nd3 nd;
        logic [16:0]   den;
        den   = (n < 17'd65025) ? n : (17'd130050 - n);
        nd[0] = mk(s40(27'(h)), 32'd1);
        priority if (n <= 17'd1) begin
            nd[1] = mk(s40(27'(s)), 32'd1);
            nd[2] = mk(40'sd0, 32'd1);
        end else if (n >= 17'd130049) begin
            nd[1] = mk(40'sd0, 32'd1);
            nd[2] = mk(40'sd255, 32'd1);
        end else begin
            nd[1] = mk(s40(27'(sv)) * 40'sd255, 32'(den));
            nd[2] = mk(s40(27'(n)), 32'd510);
        end
        return nd;
    endfunction

    function automatic t_hue f_hue(input logic [7:0] h, input logic signed [11:0] off);
        t_hue              hu;
        logic signed [11:0] t;
        t = signed'(12'(h)) * 12'sd3 + off;
        if (t < 12'sd0) t = t + 12'sd765;
        if (t > 12'sd765) t = t - 12'sd765;
        priority if (t <= 12'sd127) begin
            hu.rg = HR_RISE;
            hu.f  = 10'(t * 12'sd6);
        end else if (t <= 12'sd382) begin
            hu.rg = HR_TOP;
            hu.f  = '0;
        end else if (t <= 12'sd509) begin
            hu.rg = HR_FALL;
            hu.f  = 10'((12'sd510 - t) * 12'sd6);
        end else begin
            hu.rg = HR_LOW;
            hu.f  = '0;
        end
        return hu;
    endfunction

    function automatic csc_pkg::t_nd3 f_to_rgb(input logic [2:0] sp, input logic [7:0] a,
                                               input logic [7:0] b, input logic [7:0] c);
        csc_pkg::t_nd3      nd;
        logic signed [39:0] sa;
        logic signed [39:0] sb;
        logic signed [39:0] sc;
        logic signed [39:0] cb2;
        logic signed [39:0] cr2;
        sa  = s40(27'(a));
        sb  = s40(27'(b));
        sc  = s40(27'(c));
        cb2 = sb * 40'sd2 - 40'sd255;
        cr2 = sc * 40'sd2 - 40'sd255;
        unique case (sp)
            csc_pkg::SP_CMY: begin
                nd[0] = mk(40'sd255 - sa, 32'd1);
                nd[1] = mk(40'sd255 - sb, 32'd1);
                nd[2] = mk(40'sd255 - sc, 32'd1);
            end
            csc_pkg::SP_Y601: begin
                nd[0] = mk(sa * 40'sd1000 + cr2 * 40'sd701, 32'd1000);
                nd[1] = mk(sa * 40'sd1174000 - cr2 * 40'sd419198 - cb2 * 40'sd202008,
                           32'd1174000);
                nd[2] = mk(sa * 40'sd1000 + cb2 * 40'sd886, 32'd1000);
            end
            csc_pkg::SP_Y709: begin
                nd[0] = mk(sa * 40'sd10000 + cr2 * 40'sd7874, 32'd10000);
                nd[1] = mk(sa * 40'sd143040000 - cr2 * 40'sd33480248
                           - cb2 * 40'sd13397432, 32'd143040000);
                nd[2] = mk(sa * 40'sd10000 + cb2 * 40'sd9278, 32'd10000);
            end
            csc_pkg::SP_YCOCG: begin
                nd[0] = mk(sa + sb - sc, 32'd1);
                nd[1] = mk(sa * 40'sd2 + sc * 40'sd2 - 40'sd255, 32'd2);
                nd[2] = mk(sa - sb - sc + 40'sd255, 32'd1);
            end
            default: begin
                nd = f_ident(a, b, c);
            end
        endcase
        return nd;
    endfunction

    function automatic csc_pkg::t_nd3 f_from_rgb(input logic [2:0] sp, input logic [7:0] r,
                                                 input logic [7:0] g, input logic [7:0] b);
        csc_pkg::t_nd3      nd;
        logic signed [39:0] sr;
        logic signed [39:0] sg;
        logic signed [39:0] sb;
        logic signed [39:0] y6;
        logic signed [39:0] y7;
        sr = s40(27'(r));
        sg = s40(27'(g));
        sb = s40(27'(b));
        y6 = sr * 40'sd299 + sg * 40'sd587 + sb * 40'sd114;
        y7 = sr * 40'sd2126 + sg * 40'sd7152 + sb * 40'sd722;
        unique case (sp)
            csc_pkg::SP_CMY: begin
                nd[0] = mk(40'sd255 - sr, 32'd1);
                nd[1] = mk(40'sd255 - sg, 32'd1);
                nd[2] = mk(40'sd255 - sb, 32'd1);
            end
            csc_pkg::SP_Y601: begin
                nd[0] = mk(y6, 32'd1000);
                nd[1] = mk((sb * 40'sd1000 - y6) * 40'sd2 + 40'sd451860, 32'd3544);
                nd[2] = mk((sr * 40'sd1000 - y6) * 40'sd2 + 40'sd357510, 32'd2804);
            end
            csc_pkg::SP_Y709: begin
                nd[0] = mk(y7, 32'd10000);
                nd[1] = mk((sb * 40'sd10000 - y7) * 40'sd2 + 40'sd4731780, 32'd37112);
                nd[2] = mk((sr * 40'sd10000 - y7) * 40'sd2 + 40'sd4015740, 32'd31496);
            end
            csc_pkg::SP_YCOCG: begin
                nd[0] = mk(sr + sg * 40'sd2 + sb, 32'd4);
                nd[1] = mk(sr - sb + 40'sd255, 32'd2);
                nd[2] = mk(sg * 40'sd2 - sr - sb + 40'sd510, 32'd4);
            end
            default: begin
                nd = f_ident(r, g, b);
            end
        endcase
        return nd;
    endfunction

    logic [2:0]     r_src;
    logic [2:0]     r_tgt;
    logic [LAT-1:0] r_vld;
    logic           w_en;
    logic           w_dir_hv;
    logic           w_dir_vh;
    logic           w_direct;
    logic           w_p2_hsl;
    logic           w_p3_hsl;
    logic           w_p4_hsv;
    logic [2:0]     w_p2_sp;
    logic [2:0]     w_p3_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= csc_pkg::SP_RGB;
            r_tgt <= csc_pkg::SP_RGB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                csc_pkg::CFG_SRC: r_src <= i_cfg_data;
                csc_pkg::CFG_TGT: r_tgt <= i_cfg_data;
                default:          r_src <= r_src;
            endcase
        end
    end

    assign w_dir_hv = (r_src == csc_pkg::SP_HSL) && (r_tgt == csc_pkg::SP_HSV);
    assign w_dir_vh = (r_src == csc_pkg::SP_HSV) && (r_tgt == csc_pkg::SP_HSL);
    assign w_direct = w_dir_hv || w_dir_vh;
    assign w_p2_hsl = !w_direct && ((r_src == csc_pkg::SP_HSV) || (r_src == csc_pkg::SP_HSL));
    assign w_p3_hsl = !w_direct && ((r_tgt == csc_pkg::SP_HSV) || (r_tgt == csc_pkg::SP_HSL));
    assign w_p4_hsv = !w_direct && (r_tgt == csc_pkg::SP_HSV);
    assign w_p2_sp  = w_direct ? csc_pkg::SP_RGB : r_src;
    assign w_p3_sp  = w_direct ? csc_pkg::SP_RGB : r_tgt;

    assign w_en    = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Pass 1: direct HSL/HSV step, or HSV to HSL ahead of the RGB pass.
    csc_pkg::t_pix_in r_p0_pix;
    logic [7:0]       r_p1_h;
    logic [7:0]       r_p1_s;
    logic [7:0]       r_p1_l;
    logic [16:0]      r_p1_n;
    logic [15:0]      r_p1_sv;
    logic [15:0]      r_p1_sm;
    csc_pkg::t_nd3    r_p1_nd;
    logic [8:0]       w_p1_ns;
    csc_pkg::t_nd3    w_p1_nd;
    logic [7:0]       w1_q [3];

    assign w_p1_ns = 9'd510 - 9'(r_p0_pix.chan_b);

    always_comb begin
        priority if (w_dir_hv) begin
            w_p1_nd = f_hsv_nd(r_p1_h, r_p1_s, r_p1_l, r_p1_sm);
        end else if (r_src == csc_pkg::SP_HSV) begin
            w_p1_nd = f_hsl_nd(r_p1_h, r_p1_s, r_p1_n, r_p1_sv);
        end else begin
            w_p1_nd = f_ident(r_p1_h, r_p1_s, r_p1_l);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_pix <= i_pix;
            r_p1_h   <= r_p0_pix.chan_a;
            r_p1_s   <= r_p0_pix.chan_b;
            r_p1_l   <= r_p0_pix.chan_c;
            r_p1_n   <= 17'(w_p1_ns) * 17'(r_p0_pix.chan_c);
            r_p1_sv  <= 16'(r_p0_pix.chan_b) * 16'(r_p0_pix.chan_c);
            r_p1_sm  <= 16'(r_p0_pix.chan_b) * 16'(f_hsl_m(r_p0_pix.chan_c));
            r_p1_nd  <= w_p1_nd;
        end
    end

    // Pass 2: to RGB.
    logic [7:0]    r_p2a_x [3];
    logic [15:0]   r_p2a_ls;
    logic [16:0]   r_p2b_pp;
    logic [16:0]   r_p2b_qq;
    logic [16:0]   r_p2b_dq;
    t_hue          r_p2b_hue [3];
    logic          r_p2b_s0;
    logic [7:0]    r_p2b_l;
    csc_pkg::t_nd3 r_p2b_alt;
    logic [26:0]   r_p2c_prod [3];
    logic [16:0]   r_p2c_pp;
    logic [16:0]   r_p2c_qq;
    logic [1:0]    r_p2c_rg [3];
    logic          r_p2c_s0;
    logic [7:0]    r_p2c_l;
    csc_pkg::t_nd3 r_p2c_alt;
    csc_pkg::t_nd3 r_p2d_nd;
    logic [16:0]   w_p2_qq;
    logic [16:0]   w_p2_pp;
    csc_pkg::t_nd3 w_p2_nd;
    logic [7:0]    w2_q [3];

    always_comb begin
        if (r_p2a_x[2] <= 8'd127) begin
            w_p2_qq = 17'(r_p2a_x[2]) * 17'd255 + 17'(r_p2a_ls);
        end else begin
            w_p2_qq = (17'(r_p2a_x[2]) + 17'(r_p2a_x[1])) * 17'd255 - 17'(r_p2a_ls);
        end
        w_p2_pp = 17'(r_p2a_x[2]) * 17'd510 - w_p2_qq;
    end

    always_comb begin
        w_p2_nd = r_p2c_alt;
        if (w_p2_hsl) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (r_p2c_s0) begin
                    w_p2_nd[ch] = mk(s40(27'(r_p2c_l)), 32'd1);
                end else begin
                    unique case (r_p2c_rg[ch])
                        HR_TOP:  w_p2_nd[ch] = mk(s40(27'(r_p2c_qq)), 32'd255);
                        HR_LOW:  w_p2_nd[ch] = mk(s40(27'(r_p2c_pp)), 32'd255);
                        default: w_p2_nd[ch] = mk(s40(27'(r_p2c_pp)) * 40'sd765
                                                  + s40(r_p2c_prod[ch]), 32'd195075);
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2a_x[0]   <= w1_q[0];
            r_p2a_x[1]   <= w1_q[1];
            r_p2a_x[2]   <= w1_q[2];
            r_p2a_ls     <= 16'(w1_q[2]) * 16'(w1_q[1]);
            r_p2b_pp     <= w_p2_pp;
            r_p2b_qq     <= w_p2_qq;
            r_p2b_dq     <= w_p2_qq - w_p2_pp;
            r_p2b_hue[0] <= f_hue(r_p2a_x[0], 12'sd255);
            r_p2b_hue[1] <= f_hue(r_p2a_x[0], 12'sd0);
            r_p2b_hue[2] <= f_hue(r_p2a_x[0], -12'sd255);
            r_p2b_s0     <= r_p2a_x[1] == 8'd0;
            r_p2b_l      <= r_p2a_x[2];
            r_p2b_alt    <= f_to_rgb(w_p2_sp, r_p2a_x[0], r_p2a_x[1], r_p2a_x[2]);
            for (int ch = 0; ch < 3; ch++) begin
                r_p2c_prod[ch] <= 27'(r_p2b_dq) * 27'(r_p2b_hue[ch].f);
                r_p2c_rg[ch]   <= r_p2b_hue[ch].rg;
            end
            r_p2c_pp     <= r_p2b_pp;
            r_p2c_qq     <= r_p2b_qq;
            r_p2c_s0     <= r_p2b_s0;
            r_p2c_l      <= r_p2b_l;
            r_p2c_alt    <= r_p2b_alt;
            r_p2d_nd     <= w_p2_nd;
        end
    end

    // Pass 3: from RGB.
    logic [7:0]         r_p3a_x [3];
    logic [7:0]         r_p3a_d;
    logic [8:0]         r_p3a_sum;
    logic [10:0]        r_p3a_n;
    csc_pkg::t_nd3      r_p3b_nd;
    logic [7:0]         w_p3_mx;
    logic [7:0]         w_p3_mn;
    logic [7:0]         w_p3_d;
    logic signed [11:0] w_p3_n;
    logic [8:0]         w_p3_den;
    csc_pkg::t_nd3      w_p3_nd;
    logic [7:0]         w3_q [3];

    always_comb begin
        w_p3_mx = w2_q[0];
        w_p3_mn = w2_q[0];
        if (w2_q[1] > w_p3_mx) w_p3_mx = w2_q[1];
        if (w2_q[2] > w_p3_mx) w_p3_mx = w2_q[2];
        if (w2_q[1] < w_p3_mn) w_p3_mn = w2_q[1];
        if (w2_q[2] < w_p3_mn) w_p3_mn = w2_q[2];
        w_p3_d = w_p3_mx - w_p3_mn;
        priority if (w2_q[2] == w_p3_mx) begin
            w_p3_n = signed'(12'(w2_q[0])) - signed'(12'(w2_q[1]))
                   + signed'(12'(w_p3_d)) * 12'sd4;
        end else if (w2_q[1] == w_p3_mx) begin
            w_p3_n = signed'(12'(w2_q[2])) - signed'(12'(w2_q[0]))
                   + signed'(12'(w_p3_d)) * 12'sd2;
        end else begin
            w_p3_n = signed'(12'(w2_q[1])) - signed'(12'(w2_q[2]));
        end
        if (w_p3_n < 12'sd0) w_p3_n = w_p3_n + signed'(12'(w_p3_d)) * 12'sd6;
    end

    always_comb begin
        w_p3_den = (r_p3a_sum <= 9'd255) ? r_p3a_sum : (9'd510 - r_p3a_sum);
        if (!w_p3_hsl) begin
            w_p3_nd = f_from_rgb(w_p3_sp, r_p3a_x[0], r_p3a_x[1], r_p3a_x[2]);
        end else begin
            w_p3_nd[2] = mk(s40(27'(r_p3a_sum)), 32'd2);
            if (r_p3a_d == 8'd0) begin
                w_p3_nd[0] = mk(40'sd0, 32'd1);
                w_p3_nd[1] = mk(40'sd0, 32'd1);
            end else begin
                w_p3_nd[0] = mk(s40(27'(r_p3a_n)) * 40'sd255, 32'(r_p3a_d) * 32'd6);
                w_p3_nd[1] = mk(s40(27'(r_p3a_d)) * 40'sd255, 32'(w_p3_den));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3a_x[0] <= w2_q[0];
            r_p3a_x[1] <= w2_q[1];
            r_p3a_x[2] <= w2_q[2];
            r_p3a_d    <= w_p3_d;
            r_p3a_sum  <= 9'(w_p3_mx) + 9'(w_p3_mn);
            r_p3a_n    <= 11'(w_p3_n);
            r_p3b_nd   <= w_p3_nd;
        end
    end

    // Pass 4: HSL to HSV for an HSV target.
    logic [7:0]    r_p4a_x [3];
    logic [15:0]   r_p4a_sm;
    csc_pkg::t_nd3 r_p4b_nd;
    logic [7:0]    w4_q [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4a_x[0] <= w3_q[0];
            r_p4a_x[1] <= w3_q[1];
            r_p4a_x[2] <= w3_q[2];
            r_p4a_sm   <= 16'(w3_q[1]) * 16'(f_hsl_m(w3_q[2]));
            r_p4b_nd   <= w_p4_hsv ? f_hsv_nd(r_p4a_x[0], r_p4a_x[1], r_p4a_x[2], r_p4a_sm)
                                   : f_ident(r_p4a_x[0], r_p4a_x[1], r_p4a_x[2]);
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_div
        csc_div #(.NW(csc_pkg::NUM_W), .DW(csc_pkg::DEN_W)) u_div1 (
            .i_clk (i_clk), .i_en (w_en),
            .i_num (r_p1_nd[ch].num), .i_den (r_p1_nd[ch].den), .o_q (w1_q[ch])
        );
        csc_div #(.NW(csc_pkg::NUM_W), .DW(csc_pkg::DEN_W)) u_div2 (
            .i_clk (i_clk), .i_en (w_en),
            .i_num (r_p2d_nd[ch].num), .i_den (r_p2d_nd[ch].den), .o_q (w2_q[ch])
        );
        csc_div #(.NW(csc_pkg::NUM_W), .DW(csc_pkg::DEN_W)) u_div3 (
            .i_clk (i_clk), .i_en (w_en),
            .i_num (r_p3b_nd[ch].num), .i_den (r_p3b_nd[ch].den), .o_q (w3_q[ch])
        );
        csc_div #(.NW(csc_pkg::NUM_W), .DW(csc_pkg::DEN_W)) u_div4 (
            .i_clk (i_clk), .i_en (w_en),
            .i_num (r_p4b_nd[ch].num), .i_den (r_p4b_nd[ch].den), .o_q (w4_q[ch])
        );
    end

    assign o_pix.out_a = w4_q[0];
    assign o_pix.out_b = w4_q[1];
    assign o_pix.out_c = w4_q[2];

endmodule

// ===== src/csc_chk.sv =====
// Port-level checker for the color space converter, bound to the top level.
`timescale 1ns / 1ps

module csc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input csc_pkg::t_pix_out  o_pix
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pix))
        else $error("stalled output beat changed");

    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while output stalled");

    a_empty_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    a_rst_clr: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind color_space_converter csc_chk u_csc_chk (.*);
